>>> rtl/rmmt_pkg.sv
package rmmt_pkg;

    // Default tree geometry.
    localparam int LEAVES_DEF     = 1024;
    localparam int VALUE_BITS_DEF = 16;

    // Fixed field widths of the two channels.
    localparam int LEAF_IDX_BITS  = 10;
    localparam int NEW_VALUE_BITS = 16;
    localparam int RANGE_BITS     = 11;
    localparam int MAX_OUT_BITS   = 16;
    localparam int MIN_OUT_BITS   = 17;

    // Command codes carried on the cmd field.
    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_e;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR_WALK,
        ST_QRY_WALK,
        ST_QRY_DONE
    } state_t;

    // Strobes from the sequencer to the node memory.
    typedef struct packed {
        logic wr_en;
        logic rd_a_en;
        logic rd_b_en;
    } mem_ctl_t;

endpackage

>>> rtl/rmmt_node_mem.sv
module rmmt_node_mem
    import rmmt_pkg::*;
#(
    parameter int DEPTH     = 2 * LEAVES_DEF,
    parameter int DATA_BITS = 2 * VALUE_BITS_DEF,
    localparam int AddrBits = $clog2(DEPTH)
) (
    input  logic                 aclk,
    input  mem_ctl_t             ctl,
    input  logic [AddrBits-1:0]  wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic [AddrBits-1:0]  rd_a_addr,
    input  logic [AddrBits-1:0]  rd_b_addr,
    output logic [DATA_BITS-1:0] rd_a_data,
    output logic [DATA_BITS-1:0] rd_b_data
);

    // Each entry holds the max of a node in the upper half and the min in the lower half.
    logic [DATA_BITS-1:0] mem [DEPTH];

    // One write port and two registered read ports.
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_a_en) begin
            rd_a_data <= mem[rd_a_addr];
        end
        if (ctl.rd_b_en) begin
            rd_b_data <= mem[rd_b_addr];
        end
    end

endmodule

>>> rtl/rmmt_ctrl.sv
module rmmt_ctrl
    import rmmt_pkg::*;
#(
    parameter int LEAVES     = LEAVES_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int NodeBits  = $clog2(2 * LEAVES)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // Input transaction side
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_cmd,
    input  logic [LEAF_IDX_BITS-1:0]  s_leaf_index,
    input  logic [NEW_VALUE_BITS-1:0] s_new_value,
    input  logic [RANGE_BITS-1:0]     s_range_left,
    input  logic [RANGE_BITS-1:0]     s_range_right,
    // Finished query towards the output register
    output logic                      res_valid,
    input  logic                      res_ready,
    output logic [VALUE_BITS-1:0]     res_max,
    output logic [VALUE_BITS:0]       res_min,
    // Node memory port
    output mem_ctl_t                  mem_ctl,
    output logic [NodeBits-1:0]       wr_addr,
    output logic [2*VALUE_BITS-1:0]   wr_data,
    output logic [NodeBits-1:0]       rd_a_addr,
    output logic [NodeBits-1:0]       rd_b_addr,
    input  logic [2*VALUE_BITS-1:0]   rd_a_data,
    input  logic [2*VALUE_BITS-1:0]   rd_b_data
);

    localparam int WalkBits = NodeBits + 1;
    localparam int IdxBits  = (WalkBits > RANGE_BITS) ? WalkBits : RANGE_BITS;

    localparam logic [NodeBits-1:0]   NodeLast  = NodeBits'(2 * LEAVES - 1);
    localparam logic [NodeBits-1:0]   NodeRoot  = NodeBits'(1);
    localparam logic [IdxBits-1:0]    LeavesIdx = IdxBits'(LEAVES);
    localparam logic [VALUE_BITS:0]   EmptyMin  = {1'b1, {VALUE_BITS{1'b0}}};

    state_t                 state_reg, state_next;
    logic [NodeBits-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [NodeBits-1:0]    cur_reg, cur_next;
    logic [VALUE_BITS-1:0]  carry_max_reg, carry_max_next;
    logic [VALUE_BITS-1:0]  carry_min_reg, carry_min_next;
    logic [WalkBits-1:0]    a_reg, a_next;
    logic [WalkBits-1:0]    b_reg, b_next;
    logic                   hit_a_reg, hit_a_next;
    logic                   hit_b_reg, hit_b_next;
    logic [VALUE_BITS-1:0]  best_hi_reg, best_hi_next;
    logic [VALUE_BITS:0]    best_lo_reg, best_lo_next;

    logic [VALUE_BITS-1:0]  a_max, a_min, b_max, b_min;
    logic [VALUE_BITS-1:0]  acc_hi;
    logic [VALUE_BITS:0]    acc_lo;
    logic [VALUE_BITS-1:0]  up_max, up_min;
    logic [VALUE_BITS-1:0]  wr_value;
    logic [IdxBits-1:0]     leaf_ext, left_ext, right_ext, left_sat, right_sat;
    logic                   leaf_ok;
    logic [NodeBits-1:0]    leaf_node, parent;
    logic [WalkBits-1:0]    a_init, b_init, b_dec;

    assign a_max = rd_a_data[2*VALUE_BITS-1:VALUE_BITS];
    assign a_min = rd_a_data[VALUE_BITS-1:0];
    assign b_max = rd_b_data[2*VALUE_BITS-1:VALUE_BITS];
    assign b_min = rd_b_data[VALUE_BITS-1:0];

    // Fold the nodes read in the previous cycle into the running query result.
    always_comb begin
        acc_hi = best_hi_reg;
        acc_lo = best_lo_reg;
        if (hit_a_reg) begin
            if (a_max > acc_hi) begin
                acc_hi = a_max;
            end
            if ({1'b0, a_min} < acc_lo) begin
                acc_lo = {1'b0, a_min};
            end
        end
        if (hit_b_reg) begin
            if (b_max > acc_hi) begin
                acc_hi = b_max;
            end
            if ({1'b0, b_min} < acc_lo) begin
                acc_lo = {1'b0, b_min};
            end
        end
    end

    // Parent value on the write path: the carried child against its sibling.
    assign up_max = (a_max > carry_max_reg) ? a_max : carry_max_reg;
    assign up_min = (a_min < carry_min_reg) ? a_min : carry_min_reg;
    assign parent = cur_reg >> 1;

    // Input decoding: leaf node, saturated range bounds and walk start points.
    assign wr_value  = VALUE_BITS'(s_new_value);
    assign leaf_ext  = IdxBits'(s_leaf_index);
    assign leaf_ok   = leaf_ext < LeavesIdx;
    assign leaf_node = NodeBits'(leaf_ext + LeavesIdx);
    assign left_ext  = IdxBits'(s_range_left);
    assign right_ext = IdxBits'(s_range_right);
    assign left_sat  = (left_ext > LeavesIdx) ? LeavesIdx : left_ext;
    assign right_sat = (right_ext > LeavesIdx) ? LeavesIdx : right_ext;
    assign a_init    = WalkBits'(left_sat + LeavesIdx);
    assign b_init    = WalkBits'(right_sat + LeavesIdx);
    assign b_dec     = b_reg - WalkBits'(1);

    // Next state and memory commands.
    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cur_next       = cur_reg;
        carry_max_next = carry_max_reg;
        carry_min_next = carry_min_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        hit_a_next     = 1'b0;
        hit_b_next     = 1'b0;
        best_hi_next   = acc_hi;
        best_lo_next   = acc_lo;
        mem_ctl        = '0;
        wr_addr        = clr_cnt_reg;
        wr_data        = '0;
        rd_a_addr      = cur_reg ^ NodeRoot;
        rd_b_addr      = b_dec[NodeBits-1:0];
        s_ready        = 1'b0;
        res_valid      = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                mem_ctl.wr_en = 1'b1;
                if (clr_cnt_reg == NodeLast) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + NodeRoot;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_cmd == CMD_QUERY) begin
                        a_next       = a_init;
                        b_next       = b_init;
                        best_hi_next = '0;
                        best_lo_next = EmptyMin;
                        state_next   = ST_QRY_WALK;
                    end else if (leaf_ok) begin
                        // Store the leaf and fetch its sibling in the same cycle.
                        mem_ctl.wr_en   = 1'b1;
                        mem_ctl.rd_a_en = 1'b1;
                        wr_addr         = leaf_node;
                        wr_data         = {wr_value, wr_value};
                        rd_a_addr       = leaf_node ^ NodeRoot;
                        cur_next        = leaf_node;
                        carry_max_next  = wr_value;
                        carry_min_next  = wr_value;
                        state_next      = ST_WR_WALK;
                    end
                end
            end
            ST_WR_WALK: begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = parent;
                wr_data       = {up_max, up_min};
                if (parent == NodeRoot) begin
                    state_next = ST_IDLE;
                end else begin
                    mem_ctl.rd_a_en = 1'b1;
                    rd_a_addr       = parent ^ NodeRoot;
                    cur_next        = parent;
                    carry_max_next  = up_max;
                    carry_min_next  = up_min;
                end
            end
            ST_QRY_WALK: begin
                if (a_reg < b_reg) begin
                    mem_ctl.rd_a_en = a_reg[0];
                    mem_ctl.rd_b_en = b_reg[0];
                    rd_a_addr       = a_reg[NodeBits-1:0];
                    hit_a_next      = a_reg[0];
                    hit_b_next      = b_reg[0];
                    a_next          = (a_reg + WalkBits'(a_reg[0])) >> 1;
                    b_next          = (b_reg - WalkBits'(b_reg[0])) >> 1;
                end else begin
                    // The last reads fold in at this edge.
                    state_next = ST_QRY_DONE;
                end
            end
            ST_QRY_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            hit_a_reg   <= 1'b0;
            hit_b_reg   <= 1'b0;
            best_hi_reg <= '0;
            best_lo_reg <= EmptyMin;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            hit_a_reg   <= hit_a_next;
            hit_b_reg   <= hit_b_next;
            best_hi_reg <= best_hi_next;
            best_lo_reg <= best_lo_next;
        end
    end

    // Walk registers.
    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        carry_max_reg <= carry_max_next;
        carry_min_reg <= carry_min_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
    end

    assign res_max = best_hi_reg;
    assign res_min = best_lo_reg;

    // While no node has been folded in, the maximum must still be zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        best_lo_reg[VALUE_BITS] |-> (best_hi_reg == '0))
        else $error("query maximum moved without a node being folded in");

    // Once a node has been folded in, the minimum cannot exceed the maximum.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !best_lo_reg[VALUE_BITS] |-> (best_lo_reg[VALUE_BITS-1:0] <= best_hi_reg))
        else $error("query minimum above query maximum");

    // Walks never read the unused node zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!mem_ctl.rd_a_en || (rd_a_addr != '0)) && (!mem_ctl.rd_b_en || (rd_b_addr != '0)))
        else $error("walk read node zero");

    // The tree is not modified while a query is in progress.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_QRY_WALK) || (state_reg == ST_QRY_DONE)) |-> !mem_ctl.wr_en)
        else $error("node memory written during a query");

    // A write walk ends by writing the root and returning to idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_WR_WALK) && (wr_addr == NodeRoot)) |=> (state_reg == ST_IDLE))
        else $error("write walk did not finish at the root");

endmodule

>>> rtl/range_min_max_tree_top.sv
// Channel   Ports                                           Direction
// input     s_valid s_ready s_cmd s_leaf_index s_new_value  in
//           s_range_left s_range_right
// result    m_valid m_ready m_range_max m_range_min         out
//
// A write stores the leaf and then updates one tree level per cycle, in the single
// read-modify-write walk through the node memory. A query is accepted, walks up to
// one level per cycle over two read ports, folds in the last nodes and then hands the
// result over once the output register is free.
// After reset the node memory is cleared one entry a cycle, with s_ready low. A waiting
// result sits in the output register while the next transaction is taken; a second query
// finishes only once that result has been taken.
module range_min_max_tree_top
    import rmmt_pkg::*;
#(
    parameter int LEAVES     = LEAVES_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_cmd,
    input  logic [LEAF_IDX_BITS-1:0]  s_leaf_index,
    input  logic [NEW_VALUE_BITS-1:0] s_new_value,
    input  logic [RANGE_BITS-1:0]     s_range_left,
    input  logic [RANGE_BITS-1:0]     s_range_right,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [MAX_OUT_BITS-1:0]   m_range_max,
    output logic [MIN_OUT_BITS-1:0]   m_range_min
);

    localparam int NodeBits = $clog2(2 * LEAVES);

    mem_ctl_t                mem_ctl;
    logic [NodeBits-1:0]     wr_addr, rd_a_addr, rd_b_addr;
    logic [2*VALUE_BITS-1:0] wr_data, rd_a_data, rd_b_data;
    logic                    res_valid, res_ready;
    logic [VALUE_BITS-1:0]   res_max;
    logic [VALUE_BITS:0]     res_min;

    logic                    m_valid_reg, m_valid_next;
    logic [MAX_OUT_BITS-1:0] m_range_max_reg;
    logic [MIN_OUT_BITS-1:0] m_range_min_reg;

    rmmt_ctrl #(
        .LEAVES     (LEAVES),
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_leaf_index  (s_leaf_index),
        .s_new_value   (s_new_value),
        .s_range_left  (s_range_left),
        .s_range_right (s_range_right),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res_max       (res_max),
        .res_min       (res_min),
        .mem_ctl       (mem_ctl),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_a_addr     (rd_a_addr),
        .rd_b_addr     (rd_b_addr),
        .rd_a_data     (rd_a_data),
        .rd_b_data     (rd_b_data)
    );

    rmmt_node_mem #(
        .DEPTH     (2 * LEAVES),
        .DATA_BITS (2 * VALUE_BITS)
    ) u_node_mem (
        .aclk      (aclk),
        .ctl       (mem_ctl),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    // The output register is free when empty or when its transaction completes now.
    assign res_ready    = !m_valid_reg || m_ready;
    assign m_valid_next = (res_valid && res_ready) || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload is loaded only when a finished query moves across.
    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_range_max_reg <= MAX_OUT_BITS'(res_max);
            m_range_min_reg <= MIN_OUT_BITS'(res_min);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_range_max = m_range_max_reg;
    assign m_range_min = m_range_min_reg;

endmodule

>>> test/testbench.sv
module testbench;
    import rmmt_pkg::*;

    localparam int NODES         = 2 * LEAVES_DEF;
    localparam int RANDOM_ITEMS  = 1250;
    localparam int HOLD_CYCLES   = 500;
    localparam int DRAIN_CYCLES  = 40;
    localparam int WINDOW_WIDTH  = 64;

    // One expected query answer.
    typedef struct {
        logic [MAX_OUT_BITS-1:0] range_max;
        logic [MIN_OUT_BITS-1:0] range_min;
    } extremes_t;

    // Mirror of the two trees, and the answers still owed by the block.
    class minmax_scoreboard;
        bit [VALUE_BITS_DEF-1:0] max_tree[NODES];
        bit [VALUE_BITS_DEF-1:0] min_tree[NODES];
        extremes_t               owed_answers[$];
        int                      errors;

        // Applies an accepted transaction to the mirror and queues the answer of a query.
        function void note_transaction(cmd_e cmd, logic [LEAF_IDX_BITS-1:0] leaf,
                                       logic [NEW_VALUE_BITS-1:0] value,
                                       logic [RANGE_BITS-1:0] left,
                                       logic [RANGE_BITS-1:0] right);
            int unsigned node;
            int unsigned lo_node;
            int unsigned a;
            int unsigned b;
            int unsigned first;
            int unsigned last;
            extremes_t   answer;
            if (cmd == CMD_WRITE) begin
                if (leaf < LEAVES_DEF) begin
                    node = leaf + LEAVES_DEF;
                    max_tree[node] = value[VALUE_BITS_DEF-1:0];
                    min_tree[node] = value[VALUE_BITS_DEF-1:0];
                    for (node = node >> 1; node != 0; node = node >> 1) begin
                        lo_node = node << 1;
                        max_tree[node] = (max_tree[lo_node] > max_tree[lo_node+1]) ?
                                         max_tree[lo_node] : max_tree[lo_node+1];
                        min_tree[node] = (min_tree[lo_node] < min_tree[lo_node+1]) ?
                                         min_tree[lo_node] : min_tree[lo_node+1];
                    end
                end
            end else begin
                // Bounds past the end are clamped to the leaf count.
                first = (left > LEAVES_DEF) ? LEAVES_DEF : left;
                last  = (right > LEAVES_DEF) ? LEAVES_DEF : right;
                answer.range_max = '0;
                answer.range_min = MIN_OUT_BITS'(1 << VALUE_BITS_DEF);
                if (first < last) begin
                    a = first + LEAVES_DEF;
                    b = last + LEAVES_DEF;
                    while (a < b) begin
                        if (a[0]) begin
                            if (max_tree[a] > answer.range_max) answer.range_max = max_tree[a];
                            if (min_tree[a] < answer.range_min)
                                answer.range_min = {1'b0, min_tree[a]};
                            a++;
                        end
                        if (b[0]) begin
                            b--;
                            if (max_tree[b] > answer.range_max) answer.range_max = max_tree[b];
                            if (min_tree[b] < answer.range_min)
                                answer.range_min = {1'b0, min_tree[b]};
                        end
                        a = a >> 1;
                        b = b >> 1;
                    end
                end
                owed_answers.push_back(answer);
            end
        endfunction

        // Compares a delivered answer with the oldest one owed.
        function void check_transaction(logic [MAX_OUT_BITS-1:0] got_max,
                                        logic [MIN_OUT_BITS-1:0] got_min);
            extremes_t owed;
            if (owed_answers.size() == 0) begin
                $error("unexpected result: range_max %0d, range_min %0d", got_max, got_min);
                errors++;
            end else begin
                owed = owed_answers.pop_front();
                if (got_max !== owed.range_max) begin
                    $error("range_max: expected %0d, actual %0d", owed.range_max, got_max);
                    errors++;
                end
                if (got_min !== owed.range_min) begin
                    $error("range_min: expected %0d, actual %0d", owed.range_min, got_min);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return owed_answers.size();
        endfunction
    endclass

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic                      s_cmd;
    logic [LEAF_IDX_BITS-1:0]  s_leaf_index;
    logic [NEW_VALUE_BITS-1:0] s_new_value;
    logic [RANGE_BITS-1:0]     s_range_left;
    logic [RANGE_BITS-1:0]     s_range_right;
    logic                      m_valid;
    logic                      m_ready;
    logic [MAX_OUT_BITS-1:0]   m_range_max;
    logic [MIN_OUT_BITS-1:0]   m_range_min;

    minmax_scoreboard sb = new;
    bit               calm;
    bit               hold_request;
    int unsigned      window_base;

    range_min_max_tree_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_leaf_index  (s_leaf_index),
        .s_new_value   (s_new_value),
        .s_range_left  (s_range_left),
        .s_range_right (s_range_right),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_range_max   (m_range_max),
        .m_range_min   (m_range_min)
    );

    // Free-running clock, period 8.
    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long; none at all in calm stretches.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offers one transaction and returns at the edge where it is taken.
    task automatic send_item(cmd_e cmd, logic [LEAF_IDX_BITS-1:0] leaf,
                             logic [NEW_VALUE_BITS-1:0] value,
                             logic [RANGE_BITS-1:0] left, logic [RANGE_BITS-1:0] right);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_cmd         <= cmd;
        s_leaf_index  <= leaf;
        s_new_value   <= value;
        s_range_left  <= left;
        s_range_right <= right;
        do @(posedge aclk); while (!s_ready);
    endtask

    // The fields a command does not use carry random filler.
    task automatic write_leaf(logic [LEAF_IDX_BITS-1:0] leaf, logic [NEW_VALUE_BITS-1:0] value);
        send_item(CMD_WRITE, leaf, value, RANGE_BITS'($urandom), RANGE_BITS'($urandom));
    endtask

    task automatic query_range(logic [RANGE_BITS-1:0] left, logic [RANGE_BITS-1:0] right);
        send_item(CMD_QUERY, LEAF_IDX_BITS'($urandom), NEW_VALUE_BITS'($urandom), left, right);
    endtask

    // Random traffic, mostly focused on a small window so that answers vary.
    task automatic random_item();
        int unsigned r;
        int unsigned left;
        int unsigned leaf;
        logic [NEW_VALUE_BITS-1:0] value;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            leaf = ($urandom_range(0, 3) == 0) ? $urandom_range(0, LEAVES_DEF - 1) :
                   window_base + $urandom_range(0, WINDOW_WIDTH - 1);
            r = $urandom_range(0, 99);
            if (r < 10) value = '0;
            else if (r < 20) value = '1;
            else value = NEW_VALUE_BITS'($urandom);
            write_leaf(LEAF_IDX_BITS'(leaf), value);
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                left = window_base + $urandom_range(0, WINDOW_WIDTH);
                query_range(RANGE_BITS'(left),
                            RANGE_BITS'(left + $urandom_range(0, WINDOW_WIDTH)));
            end else if (r < 80) begin
                query_range(RANGE_BITS'($urandom), RANGE_BITS'($urandom));
            end else if (r < 90) begin
                left = $urandom_range(0, 2047);
                query_range(RANGE_BITS'(left), RANGE_BITS'($urandom_range(0, left)));
            end else begin
                query_range(RANGE_BITS'($urandom_range(0, LEAVES_DEF)),
                            RANGE_BITS'($urandom_range(LEAVES_DEF, 2047)));
            end
        end
    endtask

    // Input side monitor.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_transaction(cmd_e'(s_cmd), s_leaf_index, s_new_value,
                                s_range_left, s_range_right);
    end

    // Result side monitor.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_transaction(m_range_max, m_range_min);
    end

    // Receiver: random back-pressure, plus a long hold when the stimulus asks for one.
    initial begin
        int gap;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_cmd         <= CMD_WRITE;
        s_leaf_index  <= '0;
        s_new_value   <= '0;
        s_range_left  <= '0;
        s_range_right <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: untouched tree, empty and reversed ranges, clamped bounds,
        // extreme values at both ends of the leaf range.
        query_range(0, LEAVES_DEF);
        query_range(0, 0);
        query_range(7, 3);
        query_range(2047, 1500);
        query_range(LEAVES_DEF, 2047);
        write_leaf(0, '1);
        write_leaf(LEAVES_DEF - 1, '1);
        write_leaf(512, 1);
        query_range(0, 1);
        query_range(LEAVES_DEF - 1, 2047);
        query_range(0, 2047);
        query_range(1, LEAVES_DEF - 1);
        write_leaf(0, '0);
        write_leaf(LEAVES_DEF - 1, 16'h8000);
        query_range(0, LEAVES_DEF);
        query_range(511, 514);
        write_leaf(1, 16'hAAAA);
        write_leaf(2, 16'h5555);
        query_range(1, 3);
        query_range(0, 3);
        query_range(2, 3);
        query_range(2047, 2047);

        // Random part, with long receiver holds and a calm stretch with no idling.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            calm = (i >= 500 && i < 700);
            if (i == 300 || i == 1000)
                hold_request = 1'b1;
            if (i % 100 == 0)
                window_base = $urandom_range(0, LEAVES_DEF - WINDOW_WIDTH);
            random_item();
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        // Let the input monitor note the last transaction before counting what is owed.
        @(posedge aclk);

        // Drain the answers still owed, then allow for stray results.
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog.
    initial begin
        #8000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
